// File: rtl/aes_dec_pkg.sv
package aes_dec_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY_PART_0 = 3'd0;
  localparam logic [2:0] REG_KEY_PART_1 = 3'd1;
  localparam logic [2:0] REG_KEY_PART_2 = 3'd2;
  localparam logic [2:0] REG_KEY_PART_3 = 3'd3;
  localparam logic [2:0] REG_KEY_SIZE   = 3'd4;

  // Key size codes
  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;
  localparam logic [1:0] KS_256 = 2'd2;
  localparam logic [1:0] KS_ALT = 2'd3;

  typedef logic [127:0] state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // InvMixColumns on one column, byte 0 in the top bits
  function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2, x4, x8;
    for (int k = 0; k < 4; k++) begin
      a[k]  = w[31-8*k -: 8];
      x2    = xtime(a[k]);
      x4    = xtime(x2);
      x8    = xtime(x4);
      m9[k] = x8 ^ a[k];
      mb[k] = x8 ^ x2 ^ a[k];
      md[k] = x8 ^ x4 ^ a[k];
      me[k] = x8 ^ x4 ^ x2;
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  // InvShiftRows then InvSubBytes; byte 4c+r sits at bits 127-8(4c+r)
  function automatic state_t inv_sub_shift(input state_t st);
    state_t res;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 4 * ((c - r) & 3) + r;
        res[127-8*(4*c+r) -: 8] = INV_SBOX[st[127-8*src -: 8]];
      end
    end
    return res;
  endfunction

  function automatic state_t inv_mix_state(input state_t st);
    state_t res;
    for (int c = 0; c < 4; c++) begin
      res[127-32*c -: 32] = inv_mix_word(st[127-32*c -: 32]);
    end
    return res;
  endfunction

endpackage

// File: rtl/aes_dec_key_exp.sv
module aes_dec_key_exp
  import aes_dec_pkg::*;
#(
  parameter int MAX_KS = 2,
  parameter int MAX_NR = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [63:0]                cfg_data,
  output logic                       keys_ready,
  output logic [3:0]                 num_rounds,
  output logic [MAX_NR:0][127:0]     round_keys
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_EXPAND = 2'b10
  } kx_state_t;

  kx_state_t state_r, state_nxt;

  logic [63:0] key_part_r [4];
  logic [1:0]  key_size_r;

  logic [5:0]  wi_r, wi_nxt;
  logic [3:0]  km_r, km_nxt;
  logic [7:0]  rcon_r, rcon_nxt;
  logic [31:0] win_r [8];
  logic [MAX_NR:0][127:0] rk_r;

  logic [1:0]  ks_eff;
  logic [3:0]  nk;
  logic [3:0]  nr;
  logic [5:0]  total;
  logic [31:0] key_word;
  logic [31:0] back_word;
  logic [31:0] t;
  logic [31:0] w;
  logic [3:0]  row;
  logic        do_mix;
  logic [31:0] w_store;
  logic        restart;

  // Effective key size: code 3 acts as 256, clamp to what the store holds
  always_comb begin
    ks_eff = (key_size_r == KS_ALT) ? KS_256 : key_size_r;
    if (32'(ks_eff) > MAX_KS) begin
      ks_eff = 2'(MAX_KS);
    end
    nk    = 4'd4 + {1'b0, ks_eff, 1'b0};
    nr    = nk + 4'd6;
    total = {nr + 4'd1, 2'b00};
  end

  // Next schedule word
  always_comb begin
    key_word = wi_r[0] ? key_part_r[wi_r[2:1]][31:0] : key_part_r[wi_r[2:1]][63:32];
    unique case (ks_eff)
      KS_128:  back_word = win_r[3];
      KS_192:  back_word = win_r[5];
      default: back_word = win_r[7];
    endcase
    t = win_r[0];
    if (km_r == 4'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rcon_r, 24'h0};
    end else if (nk == 4'd8 && km_r == 4'd4) begin
      t = sub_word(t);
    end
    w        = ({2'b00, wi_r} < {4'd0, nk}) ? key_word : (back_word ^ t);
    row      = nr - wi_r[5:2];
    do_mix   = (row != 4'd0) && (row != nr);
    w_store  = do_mix ? inv_mix_word(w) : w;
  end

  assign restart = cfg_we && (cfg_index <= REG_KEY_SIZE);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    wi_nxt    = wi_r;
    km_nxt    = km_r;
    rcon_nxt  = rcon_r;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_EXPAND: begin
        wi_nxt = wi_r + 6'd1;
        km_nxt = (km_r == nk - 4'd1) ? 4'd0 : km_r + 4'd1;
        if ({2'b00, wi_r} >= {4'd0, nk} && km_r == 4'd0) begin
          rcon_nxt = xtime(rcon_r);
        end
        if (wi_r == total - 6'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (restart) begin
      state_nxt = ST_EXPAND;
      wi_nxt    = '0;
      km_nxt    = '0;
      rcon_nxt  = 8'h01;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_EXPAND;
      wi_r       <= '0;
      km_r       <= '0;
      rcon_r     <= 8'h01;
      key_size_r <= KS_128;
      for (int k = 0; k < 4; k++) key_part_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      wi_r    <= wi_nxt;
      km_r    <= km_nxt;
      rcon_r  <= rcon_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_PART_0: key_part_r[0] <= cfg_data;
          REG_KEY_PART_1: key_part_r[1] <= cfg_data;
          REG_KEY_PART_2: key_part_r[2] <= cfg_data;
          REG_KEY_PART_3: key_part_r[3] <= cfg_data;
          REG_KEY_SIZE:   key_size_r    <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  // Word window and round key rows, written in reversed round order
  always_ff @(posedge clk) begin
    if (state_r == ST_EXPAND && !restart) begin
      win_r[0] <= w;
      for (int k = 1; k < 8; k++) win_r[k] <= win_r[k-1];
      for (int j = 0; j <= MAX_NR; j++) begin
        if (row == 4'(j)) begin
          rk_r[j][127-32*wi_r[1:0] -: 32] <= w_store;
        end
      end
    end
  end

  assign keys_ready = (state_r == ST_IDLE);
  assign num_rounds = nr;
  assign round_keys = rk_r;

endmodule

// File: rtl/aes_dec_round.sv
module aes_dec_round
  import aes_dec_pkg::*;
#(
  parameter int RIDX = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [3:0]   num_rounds,
  input  logic [127:0] round_key,
  input  logic         valid_in,
  input  state_t       state_in,
  output logic         valid_out,
  output state_t       state_out
);

  logic   valid_r;
  state_t state_r, state_nxt, sub_s;

  // Full round below Nr, final round at Nr, pass-through above
  always_comb begin
    sub_s = inv_sub_shift(state_in);
    if (4'(RIDX) < num_rounds) begin
      state_nxt = inv_mix_state(sub_s) ^ round_key;
    end else if (4'(RIDX) == num_rounds) begin
      state_nxt = sub_s ^ round_key;
    end else begin
      state_nxt = state_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
    end
  end

  assign valid_out = valid_r;
  assign state_out = state_r;

endmodule

// File: rtl/aes_block_decryptor.sv
// AES-ECB block decryptor, equivalent inverse cipher, 128/192/256-bit keys.
// Input channel: in_valid/in_ready with in_cipher_high/in_cipher_low, one
// 128-bit ciphertext block per beat. Output channel: out_valid/out_ready with
// out_plain_high/out_plain_low, one plaintext block per beat, in input order.
// Config: cfg_we/cfg_index/cfg_data write key_part_0..3 and key_size.
// Any write to key_part_0..3 or key_size (and reset) starts a key
// expansion, one schedule word per cycle; in_ready is low until it is done.
// After reset the zero 128-bit key is loaded this way.
// Pipeline: one AddRoundKey stage then one stage per round, MAX_NR rounds
// (14 with the default store), the same stages for any key size; shorter
// keys pass through the upper stages. Throughput is one block per cycle while
// out_ready is high and the keys are ready, set by the one-round-per-stage datapath.
// When out_ready is low with a block waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
module aes_block_decryptor
  import aes_dec_pkg::*;
#(
  parameter int ROUND_KEY_WORDS = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_cipher_high,
  input  logic [63:0] in_cipher_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_plain_high,
  output logic [63:0] out_plain_low
);

  localparam int MAX_KS = (ROUND_KEY_WORDS >= 60) ? 2 : ((ROUND_KEY_WORDS >= 52) ? 1 : 0);
  localparam int MAX_NR = 10 + 2 * MAX_KS;

  logic                   keys_ready;
  logic [3:0]             num_rounds;
  logic [MAX_NR:0][127:0] round_keys;
  logic                   advance;
  logic                   v0_r;
  state_t                 st0_r;
  logic   [MAX_NR:0]      vld;
  state_t [MAX_NR:0]      st;

  aes_dec_key_exp #(
    .MAX_KS(MAX_KS),
    .MAX_NR(MAX_NR)
  ) u_key_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys_ready(keys_ready),
    .num_rounds(num_rounds),
    .round_keys(round_keys)
  );

  // Global stall: everything moves unless the output beat is held
  assign advance  = !vld[MAX_NR] || out_ready;
  assign in_ready = advance && keys_ready;

  // Stage 0: initial AddRoundKey
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (advance) begin
      v0_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st0_r <= {in_cipher_high, in_cipher_low} ^ round_keys[0];
    end
  end

  assign vld[0] = v0_r;
  assign st[0]  = st0_r;

  // Round stages
  for (genvar g = 1; g <= MAX_NR; g++) begin : g_round
    aes_dec_round #(
      .RIDX(g)
    ) u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .num_rounds(num_rounds),
      .round_key (round_keys[g]),
      .valid_in  (vld[g-1]),
      .state_in  (st[g-1]),
      .valid_out (vld[g]),
      .state_out (st[g])
    );
  end

  assign out_valid      = vld[MAX_NR];
  assign out_plain_high = st[MAX_NR][127:64];
  assign out_plain_low  = st[MAX_NR][63:0];

endmodule
